// ----- rtl/core/kmcd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types and constants for the key matrix change detector.
// ----------------------------------------------------------------------------
`default_nettype none

package kmcd_pkg;

    localparam int ROWS_DEFAULT    = 6;
    localparam int COLUMNS_DEFAULT = 16;
    localparam int FIELD_COLS      = 16;
    localparam int ROW_W           = 3;
    localparam int COL_W           = 4;
    localparam int ROW_FIELD_ROWS  = 8;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [ROW_W-1:0]      row_index;
        logic [FIELD_COLS-1:0] column_levels;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0] event_row;
        logic [COL_W-1:0] event_column;
        logic             pressed;
        logic             last_event;
    } out_t;

    // One row's worth of pending changes, front to back.
    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [FIELD_COLS-1:0] changed;
        logic [FIELD_COLS-1:0] down;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/core/kmcd_front.sv -----
// ----------------------------------------------------------------------------
// kmcd_front
// Holds the key-down bitmap, compares each row sample against it and pushes
// rows with changes into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kmcd_front #(
    parameter int ROWS    = kmcd_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = kmcd_pkg::COLUMNS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire kmcd_pkg::in_t  s_data,
    input  wire logic           q_full,
    output logic                q_push,
    output kmcd_pkg::job_t      q_job
);

    localparam int SCAN_COLS = (COLUMNS < kmcd_pkg::FIELD_COLS) ? COLUMNS
                                                                : kmcd_pkg::FIELD_COLS;
    localparam int MAP_ROWS  = (ROWS < kmcd_pkg::ROW_FIELD_ROWS) ? ROWS
                                                                 : kmcd_pkg::ROW_FIELD_ROWS;
    localparam int IDX_W     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

    logic [SCAN_COLS-1:0] map_reg [MAP_ROWS];

    logic                 accept;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [SCAN_COLS-1:0] now_down;
    logic [SCAN_COLS-1:0] changed;

    always_comb begin
        s_ready  = !q_full;
        accept   = s_valid && s_ready;
        in_range = int'(s_data.row_index) < MAP_ROWS;
        idx      = IDX_W'(s_data.row_index);
        now_down = ~s_data.column_levels[SCAN_COLS-1:0];
        changed  = in_range ? (now_down ^ map_reg[idx]) : '0;
        q_push   = accept && in_range && (changed != '0);
        q_job.row     = s_data.row_index;
        q_job.changed = kmcd_pkg::FIELD_COLS'(changed);
        q_job.down    = kmcd_pkg::FIELD_COLS'(now_down);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAP_ROWS; i++) begin
                map_reg[i] <= '0;
            end
        end else if (accept && in_range) begin
            map_reg[idx] <= now_down;
        end
    end

    a_map_updated: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_range) |=> (map_reg[$past(idx)] == $past(now_down)))
        else $error("key map not updated after row transfer");

    a_push_has_change: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_job.changed != '0) && !q_full)
        else $error("empty or blocked job pushed");

endmodule

`default_nettype wire

// ----- rtl/core/kmcd_queue.sv -----
// ----------------------------------------------------------------------------
// kmcd_queue
// Short job queue between the classifying front and the event back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kmcd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire kmcd_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output kmcd_pkg::job_t      head_job
);

    localparam int DEPTH = kmcd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kmcd_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    always_comb begin
        full      = (count_reg == CNT_W'(DEPTH));
        not_empty = (count_reg != '0);
        head_job  = slot_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/kmcd_back.sv -----
// ----------------------------------------------------------------------------
// kmcd_back
// Takes one job at a time and emits its key events, lowest column first,
// one per cycle while the receiver keeps taking them, into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module kmcd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire kmcd_pkg::job_t q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output kmcd_pkg::out_t      m_data
);

    localparam int FC = kmcd_pkg::FIELD_COLS;

    logic [FC-1:0]                pending_reg;
    logic [FC-1:0]                down_reg;
    logic [kmcd_pkg::ROW_W-1:0]   row_reg;
    logic                         m_valid_reg;
    kmcd_pkg::out_t               m_data_reg;

    logic                         out_free;
    logic                         emit;
    logic [FC-1:0]                low_bit;
    logic [FC-1:0]                rest;
    logic [FC-1:0]                pending_after;
    logic [kmcd_pkg::COL_W-1:0]   col;
    kmcd_pkg::out_t               ev;

    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        emit          = out_free && (pending_reg != '0);
        low_bit       = pending_reg & (~pending_reg + FC'(1));
        rest          = pending_reg & ~low_bit;
        pending_after = emit ? rest : pending_reg;
        q_pop         = q_valid && (pending_after == '0);
        col           = '0;
        for (int i = 0; i < FC; i++) begin
            if (low_bit[i]) begin
                col = col | kmcd_pkg::COL_W'(i);
            end
        end
        ev.event_row    = row_reg;
        ev.event_column = col;
        ev.pressed      = |(low_bit & down_reg);
        ev.last_event   = (rest == '0);
        m_valid         = m_valid_reg;
        m_data          = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            pending_reg <= q_pop ? q_job.changed : pending_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= ev;
        end
        if (q_pop) begin
            down_reg <= q_job.down;
            row_reg  <= q_job.row;
        end
    end

    a_single_column: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> $onehot(low_bit))
        else $error("event does not select exactly one column");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.last_event) |-> (pending_reg != '0))
        else $error("run ended without a last event");

endmodule

`default_nettype wire

// ----- rtl/core/key_matrix_change_detector.sv -----
// ----------------------------------------------------------------------------
// key_matrix_change_detector
// Path: a row's changes go through a job queue slot and the back end's pending
// register before its first event is registered at the output.
// Throughput: one row transfer per cycle while the 2-entry job queue has room;
// the back end emits one event per cycle while the receiver is ready, up to 16 events per row.
// Reset: synchronous; key map cleared (all released), queue and output emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_change_detector #(
    parameter int ROWS    = kmcd_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = kmcd_pkg::COLUMNS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire kmcd_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output kmcd_pkg::out_t      m_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    kmcd_pkg::job_t push_job;
    kmcd_pkg::job_t head_job;

    kmcd_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    kmcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    kmcd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_matrix_change_detector. Rows are sent over the
// s_ channel and every accepted row is run through a local key map that
// predicts the press and release events. Each m_ transfer is compared field
// by field with the oldest predicted event. Directed rows cover the edge
// cases, then scan-like random traffic runs with random gaps on both sides
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCAN_COLS =
        (kmcd_pkg::COLUMNS_DEFAULT < kmcd_pkg::FIELD_COLS) ? kmcd_pkg::COLUMNS_DEFAULT
                                                           : kmcd_pkg::FIELD_COLS;
    localparam logic [kmcd_pkg::FIELD_COLS-1:0] SCAN_MASK =
        (SCAN_COLS >= kmcd_pkg::FIELD_COLS) ? {kmcd_pkg::FIELD_COLS{1'b1}}
                                            : kmcd_pkg::FIELD_COLS'((1 << SCAN_COLS) - 1);
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    kmcd_pkg::in_t   s_data;
    logic            m_valid;
    logic            m_ready;
    kmcd_pkg::out_t  m_data;

    logic [kmcd_pkg::FIELD_COLS-1:0] key_down_state [kmcd_pkg::ROWS_DEFAULT];
    kmcd_pkg::out_t  expected_events [$];
    int    error_count = 0;
    bit    tx_gaps_on = 1'b0;
    bit    rx_stalls_on = 1'b0;
    int    hold_off_request = 0;

    key_matrix_change_detector u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void predict_row_events(input kmcd_pkg::in_t item);
        logic [kmcd_pkg::FIELD_COLS-1:0] now_down;
        logic [kmcd_pkg::FIELD_COLS-1:0] changed;
        int   last_col;
        kmcd_pkg::out_t ev;
        if (item.row_index >= kmcd_pkg::ROWS_DEFAULT) begin
            return;
        end
        now_down = ~item.column_levels & SCAN_MASK;
        changed  = (now_down ^ key_down_state[item.row_index]) & SCAN_MASK;
        last_col = -1;
        for (int c = 0; c < kmcd_pkg::FIELD_COLS; c++) begin
            if (changed[c]) begin
                last_col = c;
            end
        end
        for (int c = 0; c < kmcd_pkg::FIELD_COLS; c++) begin
            if (changed[c]) begin
                ev.event_row    = item.row_index;
                ev.event_column = kmcd_pkg::COL_W'(c);
                ev.pressed      = now_down[c];
                ev.last_event   = (c == last_col);
                expected_events.push_back(ev);
            end
        end
        key_down_state[item.row_index] =
            (key_down_state[item.row_index] & ~SCAN_MASK) | now_down;
    endfunction

    // Called on a rising edge; returns on the edge of the transfer with valid still high.
    task automatic send_row(input logic [kmcd_pkg::ROW_W-1:0] row,
                            input logic [kmcd_pkg::FIELD_COLS-1:0] levels);
        int   gap;
        kmcd_pkg::in_t item;
        gap = tx_gaps_on ? pick_gap() : 0;
        item.row_index     = row;
        item.column_levels = levels;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_row_events(item);
    endtask

    task automatic wait_events_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_events.size() != 0) begin
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
            expected_events.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: counted gaps, plus one long hold-off on request.
    initial begin
        int gap_left;
        int hold_len;
        gap_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request != 0) begin
                hold_len = hold_off_request;
                hold_off_request = 0;
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                    gap_left = pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        kmcd_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event row %0d col %0d pressed %0b",
                    m_data.event_row, m_data.event_column, m_data.pressed));
            end else begin
                want = expected_events.pop_front();
                if (m_data.event_row !== want.event_row)
                    report_mismatch($sformatf("event_row got %0d want %0d",
                        m_data.event_row, want.event_row));
                if (m_data.event_column !== want.event_column)
                    report_mismatch($sformatf("event_column got %0d want %0d",
                        m_data.event_column, want.event_column));
                if (m_data.pressed !== want.pressed)
                    report_mismatch($sformatf("pressed got %0b want %0b (col %0d)",
                        m_data.pressed, want.pressed, want.event_column));
                if (m_data.last_event !== want.last_event)
                    report_mismatch($sformatf("last_event got %0b want %0b (col %0d)",
                        m_data.last_event, want.last_event, want.event_column));
            end
        end
    end

    task automatic test_idle_rows();
        for (int r = 0; r < kmcd_pkg::ROWS_DEFAULT; r++) begin
            send_row(kmcd_pkg::ROW_W'(r), 16'hFFFF);
        end
        wait_events_drained();
    endtask

    task automatic test_single_keys();
        send_row(3'd0, 16'hFFFE);
        send_row(3'd0, 16'hFFFF);
        send_row(3'd5, 16'h7FFF);
        send_row(3'd5, 16'hFFFF);
        wait_events_drained();
    endtask

    task automatic test_full_row();
        send_row(3'd3, 16'h0000);
        send_row(3'd3, 16'h0000);
        send_row(3'd3, 16'hFFFF);
        send_row(3'd2, 16'hAAAA);
        send_row(3'd2, 16'h5555);
        send_row(3'd2, 16'hFFFF);
        wait_events_drained();
    endtask

    task automatic test_unused_rows();
        send_row(3'd6, 16'h0000);
        send_row(3'd7, 16'h0000);
        send_row(3'd7, 16'h1234);
        send_row(3'd0, 16'hFFFF);
        send_row(3'd1, 16'hFFFF);
        send_row(3'd4, 16'h0F0F);
        send_row(3'd4, 16'h0F0F);
        send_row(3'd4, 16'hFFFF);
        wait_events_drained();
    endtask

    task automatic test_backpressure_fill();
        logic [kmcd_pkg::ROW_W-1:0] row;
        hold_off_request = 300;
        for (int i = 0; i < 12; i++) begin
            row = kmcd_pkg::ROW_W'(i % kmcd_pkg::ROWS_DEFAULT);
            // levels equal to the stored down bits flip every key in the row
            send_row(row, key_down_state[row]);
        end
        wait_events_drained();
    endtask

    task automatic test_random_scan(input int count);
        int choice;
        logic [kmcd_pkg::ROW_W-1:0]      scan_row;
        logic [kmcd_pkg::ROW_W-1:0]      row;
        logic [kmcd_pkg::FIELD_COLS-1:0] toggles;
        logic [kmcd_pkg::FIELD_COLS-1:0] levels;
        scan_row = '0;
        for (int i = 0; i < count; i++) begin
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
                row = scan_row;
                scan_row = (scan_row == kmcd_pkg::ROWS_DEFAULT - 1) ? '0 : scan_row + 1'b1;
                toggles = '0;
                if (choice > 0) toggles[$urandom_range(0, 15)] = 1'b1;
                if (choice > 3) toggles[$urandom_range(0, 15)] = 1'b1;
                if (choice == 6) toggles = kmcd_pkg::FIELD_COLS'($urandom & $urandom);
                levels = ~(key_down_state[row] ^ toggles);
            end else if (choice < 9) begin
                row = kmcd_pkg::ROW_W'($urandom_range(0, kmcd_pkg::ROWS_DEFAULT - 1));
                levels = kmcd_pkg::FIELD_COLS'($urandom);
            end else begin
                row = kmcd_pkg::ROW_W'($urandom_range(kmcd_pkg::ROWS_DEFAULT, 7));
                levels = kmcd_pkg::FIELD_COLS'($urandom);
            end
            send_row(row, levels);
        end
        wait_events_drained();
    endtask

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        for (int r = 0; r < kmcd_pkg::ROWS_DEFAULT; r++) begin
            key_down_state[r] = '0;
        end
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_rows();
        test_single_keys();
        test_full_row();
        test_unused_rows();

        test_random_scan(40);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_random_scan(64);
        tx_gaps_on = 1'b0;
        test_random_scan(40);
        rx_stalls_on = 1'b0;
        test_backpressure_fill();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
